// File: hw/rtl/dual_quadrature_speed_distance_core_assert.svh
// Assertion macros shared by the checker of the speed and distance core.
`ifndef DUAL_QUADRATURE_SPEED_DISTANCE_CORE_ASSERT_SVH
`define DUAL_QUADRATURE_SPEED_DISTANCE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DQSD_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dqsd check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DQSD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dqsd check failed");

`endif

// File: hw/rtl/dqsd_pkg.sv
// Package: widths, types and constants of the dual quadrature speed and distance core.
package dqsd_pkg;

    localparam int STEP_WIDTH     = 16;
    localparam int DISTANCE_WIDTH = 32;
    localparam int PERIOD_WIDTH   = 16;

    typedef logic signed [STEP_WIDTH-1:0]     step_t;
    typedef logic signed [DISTANCE_WIDTH-1:0] dist_t;
    typedef logic [PERIOD_WIDTH-1:0]          period_t;

    // Saturation bounds of a step count
    localparam step_t STEP_MAX = {1'b0, {(STEP_WIDTH-1){1'b1}}};
    localparam step_t STEP_MIN = {1'b1, {(STEP_WIDTH-1){1'b0}}};

    // Update period after reset, in milliseconds
    localparam period_t PERIOD_RESET = PERIOD_WIDTH'(10);

    // Control from the top level to each encoder side
    typedef struct packed {
        logic advance;     // a sample leaves the input register this cycle
        logic primed;      // an earlier sample has set the last A level
        logic period_end;  // this sample closes an update period
    } side_ctrl_t;

endpackage

// File: hw/rtl/dqsd_if.sv
// Interfaces: pin sample channel and result channel.
interface dqsd_sample_if import dqsd_pkg::*; ();
    logic valid;
    logic ready;
    logic left_a;
    logic left_b;
    logic right_a;
    logic right_b;
    logic ms_tick;

    modport source (output valid, output left_a, output left_b, output right_a,
                    output right_b, output ms_tick, input ready);
    modport sink   (input valid, input left_a, input left_b, input right_a,
                    input right_b, input ms_tick, output ready);
endinterface

interface dqsd_result_if import dqsd_pkg::*; ();
    logic  valid;
    logic  ready;
    step_t speed_left;
    step_t speed_right;
    dist_t distance_left;
    dist_t distance_right;
    logic  period_done;

    modport source (output valid, output speed_left, output speed_right,
                    output distance_left, output distance_right, output period_done,
                    input ready);
    modport sink   (input valid, input speed_left, input speed_right,
                    input distance_left, input distance_right, input period_done,
                    output ready);
endinterface

// File: hw/rtl/dqsd_side.sv
// One encoder side: edge detection, saturating step count, speed and distance.
module dqsd_side
    import dqsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  side_ctrl_t ctrl,
    input  logic       a,
    input  logic       b,
    output step_t      speed,
    output dist_t      distance
);

    logic  last_a_reg;
    step_t step_reg;
    step_t step_next;
    step_t speed_reg;
    dist_t distance_reg;

    // Count one step on a change of A: up when A equals B, down otherwise
    always_comb
    begin
        step_next = step_reg;
        if (ctrl.primed && (a != last_a_reg))
        begin
            if (a == b)
            begin
                if (step_reg != STEP_MAX)
                    step_next = step_reg + step_t'(1);
            end
            else
            begin
                if (step_reg != STEP_MIN)
                    step_next = step_reg - step_t'(1);
            end
        end
    end

    // Side state; a period end latches the speed and folds it into the distance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_a_reg   <= 1'b0;
            step_reg     <= '0;
            speed_reg    <= '0;
            distance_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            last_a_reg <= a;
            if (ctrl.period_end)
            begin
                speed_reg    <= step_next;
                distance_reg <= distance_reg + dist_t'(step_next);
                step_reg     <= '0;
            end
            else
            begin
                step_reg <= step_next;
            end
        end
    end

    assign speed    = speed_reg;
    assign distance = distance_reg;

endmodule

// File: hw/rtl/dual_quadrature_speed_distance_core.sv
// Top level: dual quadrature encoder step counter with periodic speed and distance.
// Takes one pin sample per clock (left and right A/B levels plus a millisecond
// tick) and returns one result per sample, in order, after the sample passes
// through the input register and then the result register. A sample is
// accepted every cycle as long as the result side keeps taking results; the
// result register lets the next sample enter while a finished result waits.
// When period_reg ticks have been seen, each side's step count becomes its
// speed, is added to its 32-bit wrapping distance and is cleared, and
// period_done marks that result. Step counts saturate at 16 bits signed. A
// period of zero acts as one. Write the period through cfg_wr_en /
// cfg_wr_data only while no sample is in flight.
module dual_quadrature_speed_distance_core
    import dqsd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    dqsd_sample_if.sink    sample,
    dqsd_result_if.source  result,
    input  logic           cfg_wr_en,
    input  period_t        cfg_wr_data
);

    period_t                 period_reg;
    logic                    s1_valid_reg;
    logic                    s1_left_a_reg;
    logic                    s1_left_b_reg;
    logic                    s1_right_a_reg;
    logic                    s1_right_b_reg;
    logic                    s1_tick_reg;
    logic                    primed_reg;
    period_t                 elapsed_reg;
    period_t                 elapsed_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    done_reg;
    logic [PERIOD_WIDTH:0]   tick_count;
    logic                    period_end;
    logic                    s1_advance;
    side_ctrl_t              side_ctrl;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET;
        else if (cfg_wr_en)
            period_reg <= cfg_wr_data;
    end

    // Handshake: the input register moves on when the result register is empty or its result is being taken
    assign s1_advance   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (sample.ready)
            s1_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_left_a_reg  <= sample.left_a;
            s1_left_b_reg  <= sample.left_b;
            s1_right_a_reg <= sample.right_a;
            s1_right_b_reg <= sample.right_b;
            s1_tick_reg    <= sample.ms_tick;
        end
    end

    // Millisecond counter and period end
    assign tick_count = {1'b0, elapsed_reg} + (PERIOD_WIDTH+1)'(1);
    assign period_end = s1_tick_reg && (tick_count >= {1'b0, period_reg});

    always_comb
    begin
        elapsed_next = elapsed_reg;
        if (period_end)
            elapsed_next = '0;
        else if (s1_tick_reg)
            elapsed_next = tick_count[PERIOD_WIDTH-1:0];
    end

    // Result valid: set by a new result, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                primed_reg  <= 1'b1;
                elapsed_reg <= elapsed_next;
                done_reg    <= period_end;
            end
        end
    end

    assign side_ctrl.advance    = s1_advance;
    assign side_ctrl.primed     = primed_reg;
    assign side_ctrl.period_end = period_end;

    // Encoder sides; their speed and distance registers are the result payload
    dqsd_side u_left
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (side_ctrl),
        .a        (s1_left_a_reg),
        .b        (s1_left_b_reg),
        .speed    (result.speed_left),
        .distance (result.distance_left)
    );

    dqsd_side u_right
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (side_ctrl),
        .a        (s1_right_a_reg),
        .b        (s1_right_b_reg),
        .speed    (result.speed_right),
        .distance (result.distance_right)
    );

    assign result.valid       = out_valid_reg;
    assign result.period_done = done_reg;

endmodule

// File: hw/rtl/dqsd_checker.sv
// Checker on the top level's ports, with its bind statement.
`include "dual_quadrature_speed_distance_core_assert.svh"

module dqsd_checker
    import dqsd_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input step_t speed_left,
    input dist_t distance_left,
    input logic  period_done
);

    // A result waiting for the sink stays offered
    `DQSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // Input stalls only behind a result that is not being taken
    `DQSD_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready)

    // Values change only on a result that ends a period
    `DQSD_ASSERT_SAME(a_no_update, out_valid && !period_done,
                      $stable(distance_left) && $stable(speed_left))

    // On a freshly loaded period-end result the new speed is added to the previous distance
    `DQSD_ASSERT_SAME(a_distance_sum, $past(!out_valid || out_ready) && out_valid && period_done,
                      distance_left == ($past(distance_left) + dist_t'(speed_left)))

    // A stalled result keeps its speed
    `DQSD_ASSERT_NEXT(a_speed_hold, out_valid && !out_ready, $stable(speed_left))

endmodule

bind dual_quadrature_speed_distance_core dqsd_checker u_dqsd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (sample.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .speed_left    (result.speed_left),
    .distance_left (result.distance_left),
    .period_done   (result.period_done)
);
